FILE: sv/fdtd_2d_field_update_core_assert.svh
// assertion macros for the field update core
`ifndef FDTD_2D_FIELD_UPDATE_CORE_ASSERT_SVH
`define FDTD_2D_FIELD_UPDATE_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define FUC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequence is checked in the next cycle
`define FUC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/fdtd_pkg.sv
// shared types, constants and rounding helper for the field update core
package fdtd_pkg;

  localparam int unsigned MaxWidthDef  = 64;
  localparam int unsigned MaxHeightDef = 64;
  localparam int unsigned HaloDef      = 1;
  localparam int unsigned NumArr       = 9;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_EPASS = 2'd2,
    REQ_HPASS = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ARR_EX    = 4'd0,
    ARR_EY    = 4'd1,
    ARR_HZ    = 4'd2,
    ARR_CEX   = 4'd3,
    ARR_CEXLY = 4'd4,
    ARR_CEY   = 4'd5,
    ARR_CEYLX = 4'd6,
    ARR_CHZLX = 4'd7,
    ARR_CHZLY = 4'd8
  } arr_e;

  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'd0,
    CFG_GRID_HEIGHT = 1'd1
  } cfg_e;

  // 32x33 signed product, rounded to nearest (ties up) and shifted by 30
  function automatic logic signed [35:0] round_q30(input logic signed [64:0] prod);
    logic signed [64:0] p;
    begin
      p = prod + 65'sd536870912;
      round_q30 = 36'($signed(p[64:30]));
    end
  endfunction

endpackage

FILE: sv/fdtd_if.sv
// valid/ready channels for request and response items
interface fdtd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  cell_x;
  logic [6:0]  cell_y;
  logic [3:0]  array_sel;
  logic signed [31:0] write_word;
  modport source (output valid, req_type, cell_x, cell_y, array_sel, write_word,
                  input ready);
  modport sink (input valid, req_type, cell_x, cell_y, array_sel, write_word,
                output ready);
endinterface

interface fdtd_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] read_word;
  logic        saturated;
  modport source (output valid, read_word, saturated, input ready);
  modport sink (input valid, read_word, saturated, output ready);
endinterface

FILE: sv/fdtd_mac.sv
// shared multiply-round unit: one 32x33 product per transfer, two register stages
module fdtd_mac
  import fdtd_pkg::*;
(
  input  logic               clk_i,
  input  logic signed [31:0] coef_i,
  input  logic signed [32:0] val_i,
  output logic signed [35:0] res_o
);
  logic signed [64:0] prod_q;
  logic signed [35:0] res_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 65'(coef_i) * 65'(val_i);
    res_q  <= round_q30(prod_q);
  end

  assign res_o = res_q;
endmodule

FILE: sv/fdtd_2d_field_update_core.sv
// field update core: grid memories, step sequencer and shared multiplier
//
// channel  dir  payload
// req      in   req_type, cell_x, cell_y, array_sel, write_word
// rsp      out  read_word, saturated
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// a write goes ACC then RSP and a read ACC, RDW then RSP before the next request;
// a pass walks every interior cell in a fixed 12-step program around one
// memory read port per array and the shared multiplier.
// reset clears control and sets grid size to 64x64; memories are undefined until written.
// req stalls while a pass or response is outstanding; rsp holds until taken.
module fdtd_2d_field_update_core
  import fdtd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef,
  parameter int unsigned HALO       = HaloDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  fdtd_req_if.sink    req,
  fdtd_rsp_if.source  rsp
);
`include "fdtd_2d_field_update_core_assert.svh"

  localparam int unsigned XS    = MAX_WIDTH + 2 * HALO;
  localparam int unsigned YS    = MAX_HEIGHT + 2 * HALO;
  localparam int unsigned CELLS = XS * YS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(XS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACC  = 5'b00010,
    ST_STEP = 5'b00100,
    ST_RSP  = 5'b01000,
    ST_RDW  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [6:0] gw_q, gh_q;
  logic [CW-1:0] x_q, y_q, nx_q, ny_q;
  logic [3:0] step_q;
  logic pass_h_q, sat_q;
  logic [1:0] req_q;
  logic [3:0] sel_q;
  logic [AW-1:0] addr_q;
  logic signed [31:0] word_q, rdw_q;
  logic sel_ok_q;

  // memories, one read and one write port each
  logic signed [31:0] mem_ex [CELLS];
  logic signed [31:0] mem_ey [CELLS];
  logic signed [31:0] mem_hz [CELLS];
  logic signed [31:0] mem_c3 [CELLS];
  logic signed [31:0] mem_c4 [CELLS];
  logic signed [31:0] mem_c5 [CELLS];
  logic signed [31:0] mem_c6 [CELLS];
  logic signed [31:0] mem_c7 [CELLS];
  logic signed [31:0] mem_c8 [CELLS];
  logic signed [31:0] rd_q [NumArr];
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic signed [31:0] wdata;
  logic [NumArr-1:0] we;

  always_ff @(posedge clk_i) begin
    if (we[0]) mem_ex[waddr] <= wdata;
    if (we[1]) mem_ey[waddr] <= wdata;
    if (we[2]) mem_hz[waddr] <= wdata;
    if (we[3]) mem_c3[waddr] <= wdata;
    if (we[4]) mem_c4[waddr] <= wdata;
    if (we[5]) mem_c5[waddr] <= wdata;
    if (we[6]) mem_c6[waddr] <= wdata;
    if (we[7]) mem_c7[waddr] <= wdata;
    if (we[8]) mem_c8[waddr] <= wdata;
    rd_q[0] <= mem_ex[raddr];
    rd_q[1] <= mem_ey[raddr];
    rd_q[2] <= mem_hz[raddr];
    rd_q[3] <= mem_c3[raddr];
    rd_q[4] <= mem_c4[raddr];
    rd_q[5] <= mem_c5[raddr];
    rd_q[6] <= mem_c6[raddr];
    rd_q[7] <= mem_c7[raddr];
    rd_q[8] <= mem_c8[raddr];
  end

  // cell address x*YS+y; YS constant so this is a small constant multiply
  logic [AW-1:0] k_addr;
  assign k_addr = AW'(x_q * YS) + AW'(y_q);

  // per-cell working registers
  logic signed [31:0] hk_q, ek_q, c_a_q, c_b_q;
  logic signed [32:0] d_q;
  logic signed [35:0] t1_q;
  logic signed [37:0] acc_q;
  logic [63:0] coef_keep_q;
  logic signed [31:0] coef_m;
  logic signed [32:0] val_m;
  logic signed [35:0] mres;

  fdtd_mac u_mac (.clk_i(clk_i), .coef_i(coef_m), .val_i(val_m), .res_o(mres));

  // electric program (x=step): reads k, k-1(y), k-YS(x); writes Ex then Ey
  // 1 rd k | 2 latch k: hz,ex,ey,coefs, rd k-1 | 3 latch hz(y-1), mul cEx*Ex
  // 4 mul cExLy*dy | 5 t1, rd k-YS | 6 latch hz(x-1), acc | 7 mul cEy*Ey
  // 8 mul cEyLx*dx, write ex | 9 t1 | 10 acc | 11 write ey
  // magnetic: 1 rd k |2 latch k, rd k+YS |3 latch ey(x+1) |4 mul cHzLx*dey
  // 5 rd k+1 |6 latch ex(y+1) t1 | 7 mul cHzLy*dex | 9 acc | 11 write
  logic sat_hit;
  logic signed [31:0] sat_val;
  always_comb begin
    sat_hit = (acc_q > 38'sd2147483647) || (acc_q < -38'sd2147483648);
    if (acc_q > 38'sd2147483647) sat_val = 32'sh7fffffff;
    else if (acc_q < -38'sd2147483648) sat_val = 32'sh80000000;
    else sat_val = acc_q[31:0];
  end

  logic wr_ok;
  assign wr_ok = (32'(req.cell_x) < XS) && (32'(req.cell_y) < YS) && (req.array_sel < 4'(NumArr));

  always_comb begin
    raddr = k_addr;
    waddr = k_addr;
    wdata = sat_val;
    we = '0;
    coef_m = c_a_q;
    val_m = d_q;
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (req.valid) state_d = ST_ACC;
      ST_ACC: begin
        raddr = addr_q;
        waddr = addr_q;
        wdata = word_q;
        if (req_q == REQ_WRITE) begin
          if (sel_ok_q) we[sel_q] = 1'b1;
          state_d = ST_RSP;
        end else if (req_q == REQ_READ) begin
          state_d = ST_RDW;
        end else begin
          state_d = (nx_q == '0 || ny_q == '0) ? ST_RSP : ST_STEP;
        end
      end
      ST_RDW: state_d = ST_RSP;
      ST_STEP: begin
        if (!pass_h_q) begin
          case (step_q)
            4'd2: raddr = k_addr - AW'(1);
            4'd3: begin coef_m = c_a_q; val_m = 33'(ek_q); end
            4'd4: begin coef_m = c_b_q; val_m = d_q; end
            4'd5: raddr = k_addr - AW'(YS);
            4'd8: begin we[ARR_EX] = 1'b1; end
            4'd11: we[ARR_EY] = 1'b1;
            default: ;
          endcase
          if (step_q == 4'd7) begin coef_m = c_a_q; val_m = 33'(ek_q); end
          if (step_q == 4'd8) begin coef_m = c_b_q; val_m = d_q; end
        end else begin
          case (step_q)
            4'd2: raddr = k_addr + AW'(YS);
            4'd4: begin coef_m = c_a_q; val_m = d_q; end
            4'd5: raddr = k_addr + AW'(1);
            4'd7: begin coef_m = c_b_q; val_m = d_q; end
            4'd11: we[ARR_HZ] = 1'b1;
            default: ;
          endcase
        end
        if (step_q == 4'd11 && x_q == nx_q && y_q == ny_q) state_d = ST_RSP;
      end
      ST_RSP: if (rsp.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign req.ready = (state_q == ST_IDLE);
  assign rsp.valid = (state_q == ST_RSP);
  assign rsp.read_word = rdw_q;
  assign rsp.saturated = sat_q;

  logic [CW-1:0] gwl, ghl;
  assign gwl = (32'(gw_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(gw_q);
  assign ghl = (32'(gh_q) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(gh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gw_q <= 7'd64;
      gh_q <= 7'd64;
      step_q <= '0;
      sat_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_GRID_WIDTH) gw_q <= cfg_data_i;
        else gh_q <= cfg_data_i;
      end
      if (state_q == ST_IDLE && req.valid) begin
        sat_q <= 1'b0;
        step_q <= '0;
      end
      if (state_q == ST_STEP) begin
        if (step_q == 4'd11) step_q <= '0;
        else step_q <= step_q + 4'd1;
        if ((step_q == 4'd8 && !pass_h_q) || step_q == 4'd11) begin
          if (sat_hit) sat_q <= 1'b1;
        end
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req.valid) begin
      req_q <= req.req_type;
      sel_q <= req.array_sel;
      sel_ok_q <= wr_ok;
      addr_q <= AW'(32'(req.cell_x) * YS + 32'(req.cell_y));
      word_q <= req.write_word;
      pass_h_q <= (req.req_type == REQ_HPASS);
      rdw_q <= '0;
      nx_q <= CW'(HALO) + gwl - CW'(1);
      ny_q <= CW'(HALO) + ghl - CW'(1);
      x_q <= CW'(HALO);
      y_q <= CW'(HALO);
    end
    if (state_q == ST_RDW && sel_ok_q) rdw_q <= rd_q[sel_q];
    if (state_q == ST_STEP) begin
      if (step_q == 4'd11) begin
        if (y_q == ny_q) begin
          y_q <= CW'(HALO);
          x_q <= x_q + CW'(1);
        end else y_q <= y_q + CW'(1);
      end
      if (!pass_h_q) begin
        case (step_q)
          4'd2: begin
            hk_q <= rd_q[ARR_HZ]; ek_q <= rd_q[ARR_EX]; word_q <= rd_q[ARR_EY];
            c_a_q <= rd_q[ARR_CEX]; c_b_q <= rd_q[ARR_CEXLY];
            coef_keep_q <= {rd_q[ARR_CEYLX], rd_q[ARR_CEY]};
          end
          4'd3: d_q <= 33'(hk_q) - 33'(rd_q[ARR_HZ]);
          4'd5: t1_q <= mres;
          4'd6: begin
            acc_q <= 38'(t1_q) + 38'(mres);
            d_q <= 33'(hk_q) - 33'(rd_q[ARR_HZ]);
            ek_q <= word_q;
            c_a_q <= coef_keep_q[31:0];
            c_b_q <= coef_keep_q[63:32];
          end
          4'd9: t1_q <= mres;
          4'd10: acc_q <= 38'(t1_q) - 38'(mres);
          default: ;
        endcase
      end else begin
        case (step_q)
          4'd2: begin
            hk_q <= rd_q[ARR_HZ]; ek_q <= rd_q[ARR_EY]; word_q <= rd_q[ARR_EX];
            c_a_q <= rd_q[ARR_CHZLX]; c_b_q <= rd_q[ARR_CHZLY];
          end
          4'd3: d_q <= 33'(rd_q[ARR_EY]) - 33'(ek_q);
          4'd6: begin
            t1_q <= mres;
            d_q <= 33'(rd_q[ARR_EX]) - 33'(word_q);
          end
          4'd9: acc_q <= 38'(hk_q) - 38'(t1_q) + 38'(mres);
          default: ;
        endcase
      end
    end
  end

  `FUC_ASSERT_IMP(a_one_side, clk_i, rst_ni, rsp.valid, !req.ready, "busy while responding")
  `FUC_ASSERT_NEXT(a_hold, clk_i, rst_ni, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.read_word), "response lost")
  `FUC_ASSERT_IMP(a_step, clk_i, rst_ni, state_q != ST_STEP, step_q == 4'd0, "step counter stray")

endmodule
